>>> rtl/ocu_pkg.sv
package ocu_pkg;

  // input item: one camera event
  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] set_target_x;
    logic signed [31:0] set_target_y;
    logic signed [31:0] set_target_z;
    logic [30:0]        set_distance;
    logic signed [31:0] set_azimuth;
    logic signed [23:0] set_elevation;
  } in_t;

  // result item: eye position and target
  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] look_x;
    logic signed [31:0] look_y;
    logic signed [31:0] look_z;
  } out_t;

  // event codes
  localparam logic [2:0] FN_ORBIT = 3'd0;
  localparam logic [2:0] FN_PAN   = 3'd1;
  localparam logic [2:0] FN_ZOOM  = 3'd2;
  localparam logic [2:0] FN_PLACE = 3'd3;

  // register indexes
  localparam logic [2:0] REG_ROTATE_SPEED  = 3'd0;
  localparam logic [2:0] REG_PAN_SPEED     = 3'd1;
  localparam logic [2:0] REG_ZOOM_SPEED    = 3'd2;
  localparam logic [2:0] REG_MIN_ELEVATION = 3'd3;
  localparam logic [2:0] REG_MAX_ELEVATION = 3'd4;
  localparam logic [2:0] REG_MIN_DISTANCE  = 3'd5;

  // register reset values
  localparam logic [23:0]        RST_ROTATE_SPEED  = 24'd19661;
  localparam logic [23:0]        RST_PAN_SPEED     = 24'd131;
  localparam logic [23:0]        RST_ZOOM_SPEED    = 24'd6554;
  localparam logic signed [23:0] RST_MIN_ELEVATION = -24'sd5832704;
  localparam logic signed [23:0] RST_MAX_ELEVATION = 24'sd5832704;
  localparam logic [30:0]        RST_MIN_DISTANCE  = 31'd6554;

  // fixed point formats of the trig path
  localparam int TRIG_BITS    = 30;
  localparam int ANG_BITS     = 24;
  localparam int CORDIC_STEPS = 24;
  localparam logic [29:0] CORDIC_GAIN = 30'd652032874;

  localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

  // arctangent of 2^-i in degrees, 24 fraction bits
  function automatic logic [29:0] atan_deg(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd754974720;
      5'd1:  r = 30'd445687602;
      5'd2:  r = 30'd235489089;
      5'd3:  r = 30'd119537938;
      5'd4:  r = 30'd60000935;
      5'd5:  r = 30'd30029717;
      5'd6:  r = 30'd15018523;
      5'd7:  r = 30'd7509720;
      5'd8:  r = 30'd3754918;
      5'd9:  r = 30'd1877465;
      5'd10: r = 30'd938734;
      5'd11: r = 30'd469367;
      5'd12: r = 30'd234684;
      5'd13: r = 30'd117342;
      5'd14: r = 30'd58671;
      5'd15: r = 30'd29336;
      5'd16: r = 30'd14668;
      5'd17: r = 30'd7334;
      5'd18: r = 30'd3667;
      5'd19: r = 30'd1833;
      5'd20: r = 30'd917;
      5'd21: r = 30'd458;
      5'd22: r = 30'd229;
      5'd23: r = 30'd115;
      default: r = '0;
    endcase
    return r;
  endfunction

  // clamp to the signed 32 bit range
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7fffffff;
    else if (v < S32_MIN) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

endpackage

>>> rtl/ocu_mul.sv
module ocu_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic               busy,
  output logic signed [65:0] p
);

  localparam logic [5:0] LAST = 6'd32;

  logic signed [34:0] hi;
  logic [32:0]        lo;
  logic signed [32:0] ar;
  logic [5:0]         cnt;
  logic signed [34:0] addend;
  logic signed [34:0] sum;

  // one multiplier bit a cycle, the top bit carries negative weight
  always_comb begin
    if (lo[0]) addend = (cnt == LAST) ? -35'(ar) : 35'(ar);
    else addend = '0;
    sum = hi + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      hi   <= '0;
      lo   <= b;
      ar   <= a;
      cnt  <= '0;
    end else if (busy) begin
      hi  <= sum >>> 1;
      lo  <= {sum[0], lo[32:1]};
      cnt <= cnt + 6'd1;
      if (cnt == LAST) busy <= 1'b0;
    end
  end

  assign p = 66'({hi, lo});

endmodule

>>> rtl/ocu_cordic.sv
module ocu_cordic import ocu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [FRAC_BITS+9:0] ang,
  output logic                      busy,
  output logic signed [31:0]        sin_val,
  output logic signed [31:0]        cos_val
);

  localparam int ZW = 34;
  localparam logic signed [ZW-1:0] FULL  = ZW'(360) << ANG_BITS;
  localparam logic signed [ZW-1:0] HALF  = ZW'(180) << ANG_BITS;
  localparam logic signed [ZW-1:0] QUART = ZW'(90) << ANG_BITS;
  localparam logic [4:0] LAST = 5'(CORDIC_STEPS - 1);

  logic signed [ZW-1:0] x, y, z;
  logic                 flip;
  logic [4:0]           cnt;
  logic signed [ZW-1:0] z0, z1, zf;
  logic                 fl;
  logic signed [ZW-1:0] xs, ys, at;

  // angle into degrees with 24 fraction bits, folded into +-90
  always_comb begin
    z0 = ZW'(ang) <<< (ANG_BITS - FRAC_BITS);
    z1 = (z0 >= HALF) ? z0 - FULL : z0;
    fl = 1'b0;
    zf = z1;
    if (z1 > QUART) begin
      zf = HALF - z1;
      fl = 1'b1;
    end else if (z1 < -QUART) begin
      zf = -HALF - z1;
      fl = 1'b1;
    end
  end

  // one rotation step a cycle
  always_comb begin
    xs = x >>> cnt;
    ys = y >>> cnt;
    at = ZW'(atan_deg(cnt));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      x    <= ZW'(CORDIC_GAIN);
      y    <= '0;
      z    <= zf;
      flip <= fl;
      cnt  <= '0;
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
      cnt <= cnt + 5'd1;
      if (cnt == LAST) busy <= 1'b0;
    end
  end

  assign sin_val = 32'(y);
  assign cos_val = flip ? 32'(-x) : 32'(x);

endmodule

>>> rtl/ocu_wrap.sv
module ocu_wrap #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [65:0]       val,
  output logic                     busy,
  output logic [FRAC_BITS+8:0]     res
);

  localparam int RW = FRAC_BITS + 10;
  localparam logic [RW-1:0] FULL = RW'(360) << FRAC_BITS;
  localparam logic [6:0] LAST = 7'd65;

  logic [65:0]         mag;
  logic [RW-2:0]       rem;
  logic                neg;
  logic [6:0]          cnt;
  logic [RW-1:0]       r2;
  logic [RW-1:0]       r3;

  // restoring remainder, one dividend bit a cycle
  always_comb begin
    r2 = {rem, mag[65]};
    r3 = (r2 >= FULL) ? r2 - FULL : r2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      neg  <= val[65];
      mag  <= val[65] ? 66'(-val) : 66'(val);
      rem  <= '0;
      cnt  <= '0;
    end else if (busy) begin
      rem <= r3[RW-2:0];
      mag <= {mag[64:0], 1'b0};
      cnt <= cnt + 7'd1;
      if (cnt == LAST) busy <= 1'b0;
    end
  end

  // negative input: fold the remainder back into 0 .. 360
  always_comb begin
    if (neg && (rem != '0)) res = (RW-1)'(FULL - RW'(rem));
    else res = rem;
  end

endmodule

>>> rtl/orbit_camera_update_unit.sv
// Orbit camera update: keeps target, distance, azimuth and elevation and
// returns the eye position and target for every event item.
// Input channel in_valid/in_ready/in_item carries one event (orbit, pan,
// zoom, place or plain recompute); output channel out_valid/out_ready/
// out_item carries one result item per event.
// The block works on one item at a time. The work is done by the single
// bit-serial multiplier (five products for the eye and eleven more for a
// pan), two rotation runs for sine and cosine, and a remainder unit that
// wraps the azimuth. The result sits in an output register: the next item
// is accepted while it waits, and only the final load waits for the
// receiver to take it. Configuration is to be written through
// cfg_we/cfg_index/cfg_data only while idle; the block itself does not
// enforce this. Synchronous reset returns the pose to target zero,
// distance 10.0 and both angles zero, restores the register defaults and
// empties the output.
module orbit_camera_update_unit import ocu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  localparam int AZW = FRAC_BITS + 9;
  localparam int ELW = FRAC_BITS + 8;
  localparam int AGW = FRAC_BITS + 10;
  localparam logic signed [65:0] ONE_W = 66'(1) << FRAC_BITS;
  localparam logic signed [65:0] LIM   = 66'(89) << FRAC_BITS;
  localparam logic [30:0] DIST_RST = 31'(10) << FRAC_BITS;
  localparam logic [3:0] PAN_LAST = 4'd10;
  localparam logic [3:0] EYE_LAST = 4'd4;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_OR_M1 = 5'd1;
  localparam logic [4:0] S_OR_W1 = 5'd2;
  localparam logic [4:0] S_OR_M2 = 5'd3;
  localparam logic [4:0] S_OR_W2 = 5'd4;
  localparam logic [4:0] S_WR_W  = 5'd5;
  localparam logic [4:0] S_ZM_M1 = 5'd6;
  localparam logic [4:0] S_ZM_W1 = 5'd7;
  localparam logic [4:0] S_ZM_M2 = 5'd8;
  localparam logic [4:0] S_ZM_W2 = 5'd9;
  localparam logic [4:0] S_PLACE = 5'd10;
  localparam logic [4:0] S_TA    = 5'd11;
  localparam logic [4:0] S_TA_W  = 5'd12;
  localparam logic [4:0] S_TE    = 5'd13;
  localparam logic [4:0] S_TE_W  = 5'd14;
  localparam logic [4:0] S_PN_M  = 5'd15;
  localparam logic [4:0] S_PN_W  = 5'd16;
  localparam logic [4:0] S_EY_M  = 5'd17;
  localparam logic [4:0] S_EY_W  = 5'd18;
  localparam logic [4:0] S_OUT   = 5'd19;

  logic [4:0] st;
  logic [3:0] k;
  in_t        item;

  // configuration
  logic [23:0]        rs, ps, zs;
  logic signed [23:0] min_el, max_el;
  logic [30:0]        min_dist;

  // camera pose
  logic signed [31:0]     tx, ty, tz;
  logic [30:0]            orb_dist;
  logic [AZW-1:0]         az;
  logic signed [ELW-1:0]  el;

  // working values
  logic signed [31:0] sa, ca, se, ce, px, py, ux, uz, tt, zf;
  logic signed [35:0] acc;
  logic signed [31:0] ex, ey, ez;

  // shared units
  logic               mul_start, mul_busy;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p, pf, pt;
  logic               cor_start, cor_busy;
  logic signed [AGW-1:0] cor_ang;
  logic signed [31:0] cor_s, cor_c;
  logic               wr_start, wr_busy;
  logic signed [65:0] wr_val;
  logic [AZW-1:0]     wr_res;

  logic signed [65:0] el_src, el_lo, el_hi, el_new;

  function automatic logic signed [65:0] clamp_rng(input logic signed [65:0] v,
                                                   input logic signed [65:0] lo,
                                                   input logic signed [65:0] hi);
    logic signed [65:0] r;
    r = v;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

  ocu_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .busy(mul_busy), .p(mul_p)
  );

  ocu_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic (
    .clk(clk), .rst(rst), .start(cor_start), .ang(cor_ang),
    .busy(cor_busy), .sin_val(cor_s), .cos_val(cor_c)
  );

  ocu_wrap #(.FRAC_BITS(FRAC_BITS)) u_wrap (
    .clk(clk), .rst(rst), .start(wr_start), .val(wr_val),
    .busy(wr_busy), .res(wr_res)
  );

  assign pf = mul_p >>> FRAC_BITS;
  assign pt = mul_p >>> TRIG_BITS;
  assign in_ready = (st == S_IDLE);

  // elevation limits, upper one wins when they cross
  always_comb begin
    el_lo  = clamp_rng(66'(min_el), -LIM, LIM);
    el_hi  = clamp_rng(66'(max_el), -LIM, LIM);
    el_src = (st == S_PLACE) ? 66'(item.set_elevation) : 66'(el) + pf;
    el_new = clamp_rng(el_src, el_lo, el_hi);
  end

  // unit starts
  always_comb begin
    mul_start = (st == S_OR_M1) || (st == S_OR_M2) || (st == S_ZM_M1) ||
                (st == S_ZM_M2) || (st == S_PN_M) || (st == S_EY_M);
    cor_start = (st == S_TA) || (st == S_TE);
    cor_ang   = (st == S_TA) ? $signed(AGW'(az)) : AGW'(el);
    wr_start  = (st == S_PLACE) || ((st == S_OR_W1) && !mul_busy);
    wr_val    = (st == S_PLACE) ? 66'(item.set_azimuth) : $signed(66'(az)) - pf;
  end

  // multiplier operands for each step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st)
      S_OR_M1: begin mul_a = 33'(item.dx); mul_b = 33'(rs); end
      S_OR_M2: begin mul_a = 33'(item.dy); mul_b = 33'(rs); end
      S_ZM_M1: begin mul_a = 33'(item.dy); mul_b = 33'(zs); end
      S_ZM_M2: begin mul_a = 33'(orb_dist); mul_b = 33'(zf); end
      S_PN_M: begin
        case (k)
          4'd0:  begin mul_a = 33'(item.dx); mul_b = 33'(ps); end
          4'd1:  begin mul_a = 33'(px); mul_b = 33'(orb_dist); end
          4'd2:  begin mul_a = 33'(item.dy); mul_b = 33'(ps); end
          4'd3:  begin mul_a = 33'(py); mul_b = 33'(orb_dist); end
          4'd4:  begin mul_a = 33'(sa); mul_b = 33'(se); end
          4'd5:  begin mul_a = 33'(ca); mul_b = 33'(se); end
          4'd6:  begin mul_a = 33'(px); mul_b = 33'(ca); end
          4'd7:  begin mul_a = 33'(py); mul_b = 33'(ux); end
          4'd8:  begin mul_a = 33'(py); mul_b = 33'(ce); end
          4'd9:  begin mul_a = 33'(px); mul_b = 33'(sa); end
          default: begin mul_a = 33'(py); mul_b = 33'(uz); end
        endcase
      end
      S_EY_M: begin
        case (k)
          4'd0:    begin mul_a = 33'(ce); mul_b = 33'(sa); end
          4'd1:    begin mul_a = 33'(orb_dist); mul_b = 33'(tt); end
          4'd2:    begin mul_a = 33'(orb_dist); mul_b = 33'(se); end
          4'd3:    begin mul_a = 33'(ce); mul_b = 33'(ca); end
          default: begin mul_a = 33'(orb_dist); mul_b = 33'(tt); end
        endcase
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // sequencer, pose and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      k         <= '0;
      out_valid <= 1'b0;
      rs        <= RST_ROTATE_SPEED;
      ps        <= RST_PAN_SPEED;
      zs        <= RST_ZOOM_SPEED;
      min_el    <= RST_MIN_ELEVATION;
      max_el    <= RST_MAX_ELEVATION;
      min_dist  <= RST_MIN_DISTANCE;
      tx        <= '0;
      ty        <= '0;
      tz        <= '0;
      orb_dist  <= DIST_RST;
      az        <= '0;
      el        <= '0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          REG_ROTATE_SPEED:  rs <= cfg_data[23:0];
          REG_PAN_SPEED:     ps <= cfg_data[23:0];
          REG_ZOOM_SPEED:    zs <= cfg_data[23:0];
          REG_MIN_ELEVATION: min_el <= $signed(cfg_data[23:0]);
          REG_MAX_ELEVATION: max_el <= $signed(cfg_data[23:0]);
          REG_MIN_DISTANCE:  min_dist <= cfg_data[30:0];
          default: ;
        endcase
      end

      // output register drains independently, a reload refills it
      if (out_valid && out_ready && (st != S_OUT)) out_valid <= 1'b0;

      case (st)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_item;
            case (in_item.func)
              FN_ORBIT: st <= S_OR_M1;
              FN_ZOOM:  st <= S_ZM_M1;
              FN_PLACE: st <= S_PLACE;
              default:  st <= S_TA;
            endcase
          end
        end
        // orbit: new azimuth goes to the wrap unit, elevation is clamped
        S_OR_M1: st <= S_OR_W1;
        S_OR_W1: if (!mul_busy) st <= S_OR_M2;
        S_OR_M2: st <= S_OR_W2;
        S_OR_W2: begin
          if (!mul_busy) begin
            el <= ELW'(el_new);
            st <= S_WR_W;
          end
        end
        S_WR_W: begin
          if (!wr_busy) begin
            az <= wr_res;
            st <= S_TA;
          end
        end
        // zoom: scale factor, then scaled distance with floor
        S_ZM_M1: st <= S_ZM_W1;
        S_ZM_W1: begin
          if (!mul_busy) begin
            zf <= sat32(ONE_W - pf);
            st <= S_ZM_M2;
          end
        end
        S_ZM_M2: st <= S_ZM_W2;
        S_ZM_W2: begin
          if (!mul_busy) begin
            if (pf < $signed(66'(min_dist))) orb_dist <= min_dist;
            else if (pf > S32_MAX) orb_dist <= 31'h7fffffff;
            else orb_dist <= 31'(pf);
            st <= S_TA;
          end
        end
        // place: load the pose, azimuth through the wrap unit
        S_PLACE: begin
          tx       <= item.set_target_x;
          ty       <= item.set_target_y;
          tz       <= item.set_target_z;
          orb_dist <= item.set_distance;
          el       <= ELW'(el_new);
          st       <= S_WR_W;
        end
        // sine and cosine of both angles
        S_TA: st <= S_TA_W;
        S_TA_W: begin
          if (!cor_busy) begin
            sa <= cor_s;
            ca <= cor_c;
            st <= S_TE;
          end
        end
        S_TE: st <= S_TE_W;
        S_TE_W: begin
          if (!cor_busy) begin
            se <= cor_s;
            ce <= cor_c;
            k  <= '0;
            st <= (item.func == FN_PAN) ? S_PN_M : S_EY_M;
          end
        end
        // pan: offsets scaled by distance, moved along right and up
        S_PN_M: st <= S_PN_W;
        S_PN_W: begin
          if (!mul_busy) begin
            case (k)
              4'd0, 4'd1: px <= sat32(pf);
              4'd2, 4'd3: py <= sat32(pf);
              4'd4:  ux <= 32'(-pt);
              4'd5:  uz <= 32'(-pt);
              4'd6:  acc <= 36'(tx) - 36'(pt);
              4'd7:  tx <= sat32(66'(acc) + pt);
              4'd8:  ty <= sat32(66'(ty) + pt);
              4'd9:  acc <= 36'(tz) + 36'(pt);
              default: tz <= sat32(66'(acc) + pt);
            endcase
            if (k == PAN_LAST) begin
              k  <= '0;
              st <= S_EY_M;
            end else begin
              k  <= k + 4'd1;
              st <= S_PN_M;
            end
          end
        end
        // eye: target plus the spherical offset
        S_EY_M: st <= S_EY_W;
        S_EY_W: begin
          if (!mul_busy) begin
            case (k)
              4'd0, 4'd3: tt <= 32'(pt);
              4'd1: ex <= sat32(66'(tx) + pt);
              4'd2: ey <= sat32(66'(ty) + pt);
              default: ez <= sat32(66'(tz) + pt);
            endcase
            if (k == EYE_LAST) begin
              st <= S_OUT;
            end else begin
              k  <= k + 4'd1;
              st <= S_EY_M;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            out_item.eye_x  <= ex;
            out_item.eye_y  <= ey;
            out_item.eye_z  <= ez;
            out_item.look_x <= tx;
            out_item.look_y <= ty;
            out_item.look_z <= tz;
            st              <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/ocu_checker.sv
module ocu_checker import ocu_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_item,
  input logic out_valid,
  input logic out_ready,
  input out_t out_item
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result item present after reset");

  // one item at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while working");

  // a new result only appears at the end of a work period
  a_result_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result item appeared without work");

endmodule

bind orbit_camera_update_unit ocu_checker u_ocu_checker (.*);
